>>> hw/rtl/flss_pkg.sv
package flss_pkg;

    // Sizes of the line stack and of the fixed-point words.
    localparam int MAX_LINES = 64;
    localparam int LINE_W    = 6;
    localparam int N_W       = 7;
    localparam int LIM_W     = 10;
    localparam int LIMQ_W    = 18;
    localparam int OFF_W     = 20;
    localparam int SPEED_W   = 16;
    localparam int MS_W      = 8;
    localparam int HEIGHT_W  = 10;
    localparam int CLIP_W    = 11;
    localparam int PIVOT_W   = 19;
    localparam int CARRY_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Shared divider: left-aligned dividend, remainder as wide as the largest divisor.
    localparam int DIV_W      = 18;
    localparam int REM_W      = 16;
    localparam int DIV_CNT_W  = 6;
    localparam int SHIFT_BITS = 16;
    localparam int CEIL_BITS  = 11;
    localparam int PIVOT_BITS = 18;

    // Pixels per second times milliseconds, with Q1.14 and Q.8 folded in.
    localparam logic [REM_W-1:0] STEP_DIVISOR = 16'd64000;

    // The divide by 64000 is a shift by 9 and then a multiply by 2^37/125,
    // rounded up, which is exact for every 31-bit shifted product.
    localparam int PROD_W      = 40;
    localparam int STEP_PRE    = 9;
    localparam int STEP_Y_W    = 31;
    localparam int RECIP_SHIFT = 37;
    localparam int RECIP_W     = 62;
    localparam int STEP_Q_W    = 25;
    localparam logic [STEP_Y_W-1:0] STEP_RECIP = 31'd1099511628;

    // Register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 2'd2;

    localparam logic [LIM_W-1:0]   LIMIT_RESET = 10'd64;
    localparam logic [N_W-1:0]     LINES_RESET = 7'd32;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd0;

    // Operation codes.
    localparam logic OP_SCROLL = 1'b0;
    localparam logic OP_SCALE  = 1'b1;

    typedef enum logic [1:0] {
        DIV_SHIFT,
        DIV_CEIL,
        DIV_PIVOT
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SMUL,
        ST_SDIV,
        ST_SCLAMP,
        ST_SWRAP,
        ST_LMUL,
        ST_LDIV,
        ST_LWAIT,
        ST_CSTART,
        ST_CWAIT,
        ST_PSTART,
        ST_PWAIT,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_in;
        logic     mul_step;
        logic     recip_mul;
        logic     div_start;
        div_sel_t div_sel;
        logic     clamp;
        logic     wrap;
        logic     line_mul;
        logic     ceil_zero;
        logic     ceil_take;
        logic     emit;
    } flss_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_busy;
        logic x_pos;
        logic last_line;
        logic slot_free;
        logic op_scale;
    } flss_stat_t;

endpackage

>>> hw/rtl/flss_div.sv
module flss_div
    import flss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_W-1:0]     dividend,
    input  logic [REM_W-1:0]     divisor,
    input  logic [DIV_CNT_W-1:0] steps,
    output logic                 busy,
    output logic [DIV_W-1:0]     quot,
    output logic [REM_W-1:0]     rem
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     quot_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [REM_W-1:0]     div_reg;

    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;
    logic             fits;
    logic [REM_W-1:0] rem_next;

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb
    begin
        trial    = {rem_reg, quot_reg[DIV_W-1]};
        diff     = trial - {1'b0, div_reg};
        fits     = (trial >= {1'b0, div_reg});
        rem_next = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
    end

    // The dividend comes in left-aligned, so the quotient ends in the low bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[DIV_W-2:0], fits};
            rem_reg  <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

>>> hw/rtl/flss_dp.sv
module flss_dp
    import flss_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DAT_W-1:0]        cfg_data,
    input  logic                        opcode,
    input  logic signed [SPEED_W-1:0]   normalized_speed,
    input  logic [MS_W-1:0]             frame_ms,
    input  logic [HEIGHT_W-1:0]         target_height,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [LINE_W-1:0]           line_index,
    output logic [CLIP_W-1:0]           clip_x,
    output logic [HEIGHT_W-1:0]         line_height,
    output logic signed [PIVOT_W-1:0]   pivot_y,
    output logic                        pivot_valid,
    output logic                        last,
    input  flss_cmd_t                   cmd,
    output flss_stat_t                  stat
);

    // Configuration registers.
    logic [LIM_W-1:0]   limit_reg;
    logic [N_W-1:0]     lines_reg;
    logic [SPEED_W-1:0] speed_reg;

    // Item and working registers.
    logic                      op_reg;
    logic                      ns_neg_reg;
    logic [SPEED_W-1:0]        ns_mag_reg;
    logic [HEIGHT_W-1:0]       th_reg;
    logic [SPEED_W+MS_W-1:0]   prod1_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [RECIP_W-1:0]        recip_reg;
    logic signed [OFF_W-1:0]   step_reg;
    logic signed [OFF_W-1:0]   offset_reg;
    logic [LINE_W-1:0]         line_reg;
    logic [LIMQ_W+LINE_W-1:0]  a_reg;
    logic [HEIGHT_W-1:0]       fh_reg;
    logic signed [CARRY_W-1:0] carry_reg;
    logic [HEIGHT_W-1:0]       sum_reg;

    // Output register.
    logic                      out_valid_reg;
    logic [LINE_W-1:0]         out_index_reg;
    logic [CLIP_W-1:0]         out_clip_reg;
    logic [HEIGHT_W-1:0]       out_height_reg;
    logic [PIVOT_W-1:0]        out_pivot_reg;
    logic                      out_pvalid_reg;
    logic                      out_last_reg;

    // Divider connections.
    logic [DIV_W-1:0]     div_dividend;
    logic [REM_W-1:0]     div_divisor;
    logic [DIV_CNT_W-1:0] div_steps;
    logic                 div_busy;
    logic [DIV_W-1:0]     quot;
    logic [REM_W-1:0]     rem;

    // Combinational values.
    logic [N_W-1:0]            n_eff;
    logic [N_W-1:0]            n_m1;
    logic [LIM_W-1:0]          lim_px;
    logic [LIMQ_W-1:0]         lim_q;
    logic [SPEED_W-1:0]        ns_abs;
    logic [SPEED_W+MS_W-1:0]   prod1_w;
    logic [PROD_W-1:0]         prod_w;
    logic [RECIP_W-1:0]        recip_w;
    logic [STEP_Q_W-1:0]       step_q;
    logic [LIMQ_W-1:0]         step_mag;
    logic [OFF_W-1:0]          step_mag_w;
    logic [OFF_W-1:0]          step_w;
    logic signed [OFF_W:0]     lim_s;
    logic signed [OFF_W:0]     off_sum;
    logic signed [OFF_W:0]     off_wrap;
    logic signed [OFF_W:0]     off_sat;
    logic [OFF_W-1:0]          off_neg;
    logic [LIMQ_W-1:0]         off_abs;
    logic [LIMQ_W+LINE_W-1:0]  a_w;
    logic signed [HEIGHT_W+1:0] x_w;
    logic [CEIL_BITS-1:0]      x_plus;
    logic                      x_pos;
    logic [LIM_W+1:0]          clip_w;
    logic [PIVOT_W-1:0]        piv_w;
    logic                      pv_w;
    logic                      last_line;
    logic                      slot_free;

    // Effective line count and limit.
    always_comb
    begin
        if (lines_reg == '0)
        begin
            n_eff = N_W'(1);
        end
        else if (lines_reg > N_W'(MAX_LINES))
        begin
            n_eff = N_W'(MAX_LINES);
        end
        else
        begin
            n_eff = lines_reg;
        end
        n_m1   = n_eff - 1'b1;
        lim_px = (limit_reg == '0) ? LIM_W'(1) : limit_reg;
        lim_q  = {lim_px, 8'b0};
    end

    // Scroll step product, split over two registered multiplies, then the
    // divide by 64000 as a shift and a registered reciprocal multiply.
    always_comb
    begin
        ns_abs  = normalized_speed[SPEED_W-1] ? (~normalized_speed + 1'b1) : normalized_speed;
        prod1_w = speed_reg * frame_ms;
        prod_w  = prod1_reg * ns_mag_reg;
        recip_w = prod_reg[PROD_W-1:STEP_PRE] * STEP_RECIP;
        step_q  = recip_reg[RECIP_W-1:RECIP_SHIFT];
    end

    // Clamp the step magnitude to the limit and restore its sign.
    always_comb
    begin
        if (step_q > {{(STEP_Q_W-LIMQ_W){1'b0}}, lim_q})
        begin
            step_mag = lim_q;
        end
        else
        begin
            step_mag = step_q[LIMQ_W-1:0];
        end
        step_mag_w = {{(OFF_W-LIMQ_W){1'b0}}, step_mag};
        step_w     = ns_neg_reg ? (~step_mag_w + 1'b1) : step_mag_w;
    end

    // Add the step, wrap once, then saturate inside the open range.
    always_comb
    begin
        lim_s   = $signed({{(OFF_W+1-LIMQ_W){1'b0}}, lim_q});
        off_sum = $signed({offset_reg[OFF_W-1], offset_reg})
                + $signed({step_reg[OFF_W-1], step_reg});
        if (off_sum >= lim_s)
        begin
            off_wrap = off_sum - lim_s;
        end
        else if (off_sum <= -lim_s)
        begin
            off_wrap = off_sum + lim_s;
        end
        else
        begin
            off_wrap = off_sum;
        end
        if (off_wrap >= lim_s)
        begin
            off_sat = lim_s - 21'sd1;
        end
        else if (off_wrap <= -lim_s)
        begin
            off_sat = 21'sd1 - lim_s;
        end
        else
        begin
            off_sat = off_wrap;
        end
    end

    // Per-line scroll product of offset magnitude and line number.
    always_comb
    begin
        off_neg = ~offset_reg + 1'b1;
        off_abs = offset_reg[OFF_W-1] ? off_neg[LIMQ_W-1:0] : offset_reg[LIMQ_W-1:0];
        a_w     = off_abs * line_reg;
    end

    // Scale: target plus the carry, and the ceil bias.
    always_comb
    begin
        x_w    = $signed({2'b0, th_reg})
               + $signed({{(HEIGHT_W+2-CARRY_W){carry_reg[CARRY_W-1]}}, carry_reg});
        x_pos  = !x_w[HEIGHT_W+1] && (x_w != '0);
        x_plus = x_w[CEIL_BITS-1:0] + {{(CEIL_BITS-N_W){1'b0}}, n_m1};
    end

    // Divider operand selection.
    always_comb
    begin
        case (cmd.div_sel)
            DIV_SHIFT:
            begin
                div_dividend = {a_reg[LIMQ_W+LINE_W-1:8], {(DIV_W-SHIFT_BITS){1'b0}}};
                div_divisor  = {{(REM_W-N_W){1'b0}}, n_eff};
                div_steps    = DIV_CNT_W'(SHIFT_BITS);
            end
            DIV_CEIL:
            begin
                div_dividend = {x_plus, {(DIV_W-CEIL_BITS){1'b0}}};
                div_divisor  = {{(REM_W-N_W){1'b0}}, n_eff};
                div_steps    = DIV_CNT_W'(CEIL_BITS);
            end
            default:
            begin
                div_dividend = {sum_reg, {(DIV_W-HEIGHT_W){1'b0}}};
                div_divisor  = {{(REM_W-HEIGHT_W){1'b0}}, fh_reg};
                div_steps    = DIV_CNT_W'(PIVOT_BITS);
            end
        endcase
    end

    flss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .busy     (div_busy),
        .quot     (quot),
        .rem      (rem)
    );

    // Result fields of the line being emitted.
    always_comb
    begin
        if (offset_reg[OFF_W-1])
        begin
            clip_w = {2'b0, lim_px} + {2'b0, quot[LIM_W-1:0]};
        end
        else
        begin
            clip_w = {2'b0, lim_px} - {2'b0, quot[LIM_W-1:0]};
        end
        piv_w     = ~{1'b0, quot[PIVOT_BITS-1:0]} + 1'b1;
        pv_w      = (op_reg == OP_SCALE) && (fh_reg != '0);
        last_line = (op_reg == OP_SCALE) ? (line_reg == '0)
                                         : (line_reg == n_m1[LINE_W-1:0]);
        slot_free = !out_valid_reg || out_ready;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            lines_reg <= LINES_RESET;
            speed_reg <= SPEED_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LIMIT: limit_reg <= cfg_data[LIM_W-1:0];
                CFG_LINES: lines_reg <= cfg_data[N_W-1:0];
                CFG_SPEED: speed_reg <= cfg_data[SPEED_W-1:0];
                default:   ;
            endcase
        end
    end

    // Scroll offset and scale carry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            carry_reg  <= '0;
        end
        else
        begin
            if (cmd.wrap)
            begin
                offset_reg <= off_sat[OFF_W-1:0];
            end
            if (cmd.load_in)
            begin
                carry_reg <= '0;
            end
            else if (cmd.ceil_zero)
            begin
                carry_reg <= x_w[CARRY_W-1:0];
            end
            else if (cmd.ceil_take)
            begin
                carry_reg <= rem[CARRY_W-1:0] - n_m1;
            end
        end
    end

    // Working registers of the current item.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg     <= opcode;
            ns_neg_reg <= normalized_speed[SPEED_W-1];
            ns_mag_reg <= ns_abs;
            th_reg     <= target_height;
            prod1_reg  <= prod1_w;
            line_reg   <= (opcode == OP_SCALE) ? n_m1[LINE_W-1:0] : '0;
            sum_reg    <= '0;
        end
        else if (cmd.emit)
        begin
            if (op_reg == OP_SCALE)
            begin
                line_reg <= line_reg - 1'b1;
                sum_reg  <= sum_reg + fh_reg;
            end
            else
            begin
                line_reg <= line_reg + 1'b1;
            end
        end
        if (cmd.mul_step)
        begin
            prod_reg <= prod_w;
        end
        if (cmd.recip_mul)
        begin
            recip_reg <= recip_w;
        end
        if (cmd.clamp)
        begin
            step_reg <= $signed(step_w);
        end
        if (cmd.line_mul)
        begin
            a_reg <= a_w;
        end
        if (cmd.ceil_zero)
        begin
            fh_reg <= '0;
        end
        else if (cmd.ceil_take)
        begin
            fh_reg <= quot[HEIGHT_W-1:0];
        end
    end

    // Output register: filled on emit, emptied when the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_index_reg  <= line_reg;
            out_clip_reg   <= (op_reg == OP_SCALE) ? '0 : clip_w[CLIP_W-1:0];
            out_height_reg <= (op_reg == OP_SCALE) ? fh_reg : '0;
            out_pivot_reg  <= pv_w ? piv_w : '0;
            out_pvalid_reg <= pv_w;
            out_last_reg   <= last_line;
        end
    end

    assign out_valid   = out_valid_reg;
    assign line_index  = out_index_reg;
    assign clip_x      = out_clip_reg;
    assign line_height = out_height_reg;
    assign pivot_y     = $signed(out_pivot_reg);
    assign pivot_valid = out_pvalid_reg;
    assign last        = out_last_reg;

    assign stat.div_busy  = div_busy;
    assign stat.x_pos     = x_pos;
    assign stat.last_line = last_line;
    assign stat.slot_free = slot_free;
    assign stat.op_scale  = (op_reg == OP_SCALE);

    // A line is never written over a result that is still waiting.
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> slot_free)
        else $error("line emitted into a full output register");

    // The shared divider is never restarted in the middle of a division.
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

    // The ceil carry never becomes positive.
    a_carry: assert property (@(posedge clk) disable iff (!rst_n)
        carry_reg[CARRY_W-1] || (carry_reg == '0))
        else $error("scale carry is positive");

    // A valid pivot always comes with a nonzero height.
    a_pivot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_pvalid_reg) |-> (out_height_reg != '0))
        else $error("pivot valid on a zero-height line");

endmodule

>>> hw/rtl/flss_ctrl.sv
module flss_ctrl
    import flss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       opcode,
    input  flss_stat_t stat,
    output flss_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_SHIFT;
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = (opcode == OP_SCALE) ? ST_CSTART : ST_SMUL;
                end
            end
            ST_SMUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = ST_SDIV;
            end
            ST_SDIV:
            begin
                cmd.recip_mul = 1'b1;
                state_next    = ST_SCLAMP;
            end
            ST_SCLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = ST_SWRAP;
            end
            ST_SWRAP:
            begin
                cmd.wrap   = 1'b1;
                state_next = ST_LMUL;
            end
            ST_LMUL:
            begin
                cmd.line_mul = 1'b1;
                state_next   = ST_LDIV;
            end
            ST_LDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SHIFT;
                state_next    = ST_LWAIT;
            end
            ST_LWAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_CSTART:
            begin
                if (stat.x_pos)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_CEIL;
                    state_next    = ST_CWAIT;
                end
                else
                begin
                    cmd.ceil_zero = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_CWAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.ceil_take = 1'b1;
                    state_next    = ST_PSTART;
                end
            end
            ST_PSTART:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_PIVOT;
                state_next    = ST_PWAIT;
            end
            ST_PWAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.last_line)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = stat.op_scale ? ST_CSTART : ST_LMUL;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/floor_line_scroll_scale.sv
// Floor line raster engine: one item in, one result per floor line out.
// Input channel (in_valid/in_ready) carries opcode, normalized_speed, frame_ms
// and target_height. A scroll item moves the stored Q.8 offset and returns the
// clip x of every line from the top down; a scale item splits target_height
// over the lines from the bottom up and returns each height and its Q.8 pivot.
// The output channel (out_valid/out_ready) carries one result per line, with
// last set on the final line of an input. Registers are to be written through
// cfg_we, cfg_index and cfg_data only while the block is idle; the block
// itself does not enforce this. A scroll item first updates the offset (two
// multiplies, a reciprocal multiply for the divide by 64000, clamp and wrap)
// and then works out each line around a 16-bit shift divide on a radix-2
// divider, one quotient bit per cycle. A scale item runs an 11-bit ceil divide
// and an 18-bit pivot divide for each line of nonzero height. One item is
// processed at a time; the next item is taken as soon as the last line sits
// in the output register.
// When the receiver stalls, the next line is worked out and then held until
// the output register is free. Reset empties the output register, clears the
// scroll offset and loads the register reset values.
module floor_line_scroll_scale
    import flss_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DAT_W-1:0]      cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      opcode,
    input  logic signed [SPEED_W-1:0] normalized_speed,
    input  logic [MS_W-1:0]           frame_ms,
    input  logic [HEIGHT_W-1:0]       target_height,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [LINE_W-1:0]         line_index,
    output logic [CLIP_W-1:0]         clip_x,
    output logic [HEIGHT_W-1:0]       line_height,
    output logic signed [PIVOT_W-1:0] pivot_y,
    output logic                      pivot_valid,
    output logic                      last
);

    flss_cmd_t  cmd;
    flss_stat_t stat;

    // Sequencer.
    flss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Arithmetic, state and output register.
    flss_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .opcode           (opcode),
        .normalized_speed (normalized_speed),
        .frame_ms         (frame_ms),
        .target_height    (target_height),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .line_index       (line_index),
        .clip_x           (clip_x),
        .line_height      (line_height),
        .pivot_y          (pivot_y),
        .pivot_valid      (pivot_valid),
        .last             (last),
        .cmd              (cmd),
        .stat             (stat)
    );

endmodule

>>> dv/floor_line_scroll_scale_test.sv
`timescale 1ns / 100ps

module floor_line_scroll_scale_test;
    import flss_pkg::*;

    // Register index that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Longest wait for the line results of one item to drain.
    localparam int DRAIN_CYCLES = 200000;

    // One line result as the block returns it.
    typedef struct packed {
        logic [LINE_W-1:0]   idx;
        logic [CLIP_W-1:0]   clip;
        logic [HEIGHT_W-1:0] height;
        logic [PIVOT_W-1:0]  pivot;
        logic                pvalid;
        logic                last_flag;
    } line_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DAT_W-1:0]      cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic                      opcode;
    logic signed [SPEED_W-1:0] normalized_speed;
    logic [MS_W-1:0]           frame_ms;
    logic [HEIGHT_W-1:0]       target_height;
    logic                      out_valid;
    logic                      out_ready;
    logic [LINE_W-1:0]         line_index;
    logic [CLIP_W-1:0]         clip_x;
    logic [HEIGHT_W-1:0]       line_height;
    logic signed [PIVOT_W-1:0] pivot_y;
    logic                      pivot_valid;
    logic                      last;

    // Register copies and scroll offset held by the line predictor.
    logic [LIM_W-1:0]   model_limit;
    logic [N_W-1:0]     model_lines;
    logic [SPEED_W-1:0] model_speed;
    longint             model_offset;

    // Line results still owed by the block, oldest first.
    line_t line_q[$];
    line_t got;

    int err_count;
    int n_scroll;
    int n_scale;
    int n_checked;
    bit idle_on;

    floor_line_scroll_scale i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .normalized_speed (normalized_speed),
        .frame_ms         (frame_ms),
        .target_height    (target_height),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .line_index       (line_index),
        .clip_x           (clip_x),
        .line_height      (line_height),
        .pivot_y          (pivot_y),
        .pivot_valid      (pivot_valid),
        .last             (last)
    );

    // 10 ns clock.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Register write as the block sees it, including masking and ignored indexes.
    function automatic void model_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DAT_W-1:0] data);
        if (idx == CFG_LIMIT)
            model_limit = data[LIM_W-1:0];
        else if (idx == CFG_LINES)
            model_lines = data[N_W-1:0];
        else if (idx == CFG_SPEED)
            model_speed = data[SPEED_W-1:0];
    endfunction

    // Work out the line results of one accepted item and queue them.
    function automatic void predict_lines(input logic op, input logic [SPEED_W-1:0] ns,
                                          input logic [MS_W-1:0] ms,
                                          input logic [HEIGHT_W-1:0] th);
        longint n;
        longint lim_px;
        longint lim;
        longint step;
        longint off;
        longint shift;
        longint h;
        longint carry;
        longint x;
        longint fh;
        longint mag;
        longint sum;
        line_t  r;

        // A line count of zero acts as one, above the stack size as the stack size.
        n = longint'(model_lines);
        if (n == 0)
            n = 1;
        if (n > MAX_LINES)
            n = MAX_LINES;
        lim_px = (model_limit == '0) ? 1 : longint'(model_limit);

        if (op == OP_SCROLL)
        begin
            // Step in Q.8, clamped, then one wrap and a final saturation.
            lim  = lim_px * 256;
            step = (longint'(model_speed) * longint'($signed(ns)) * longint'(ms))
                   / longint'(STEP_DIVISOR);
            if (step > lim)
                step = lim;
            if (step < -lim)
                step = -lim;
            off = model_offset + step;
            if (off >= lim)
                off = off - lim;
            else if (off <= -lim)
                off = off + lim;
            if (off >= lim)
                off = lim - 1;
            if (off <= -lim)
                off = -(lim - 1);
            model_offset = off;

            // Lines from the top down, each shifted by its share of the offset.
            for (longint i = 0; i < n; i++)
            begin
                shift       = (off * i) / (n * 256);
                r.idx       = LINE_W'(i);
                r.clip      = CLIP_W'(lim_px - shift);
                r.height    = '0;
                r.pivot     = '0;
                r.pvalid    = 1'b0;
                r.last_flag = (i == n - 1);
                line_q      = {line_q, r};
            end
        end
        else
        begin
            // Lines from the bottom up, ceil split with exact error carry.
            h     = longint'(th);
            carry = 0;
            sum   = 0;
            for (longint i = n - 1; i >= 0; i--)
            begin
                x     = h + carry;
                fh    = (x <= 0) ? 0 : (x + n - 1) / n;
                carry = carry + h - fh * n;
                r.idx       = LINE_W'(i);
                r.clip      = '0;
                r.height    = HEIGHT_W'(fh);
                r.pivot     = '0;
                r.pvalid    = 1'b0;
                r.last_flag = (i == 0);
                if (fh > 0)
                begin
                    mag      = (sum * 256) / fh;
                    r.pivot  = PIVOT_W'(-mag);
                    r.pvalid = 1'b1;
                    sum      = sum + fh;
                end
                line_q = {line_q, r};
            end
        end
    endfunction

    function automatic void log_error(input string what, input line_t want,
                                      input line_t seen);
        err_count++;
        if (err_count <= 10)
        begin
            $display("%s: expected line %0d clip %0d height %0d pivot %0d valid %0b last %0b,",
                     what, want.idx, want.clip, want.height, $signed(want.pivot),
                     want.pvalid, want.last_flag);
            $display("    got line %0d clip %0d height %0d pivot %0d valid %0b last %0b",
                     seen.idx, seen.clip, seen.height, $signed(seen.pivot),
                     seen.pvalid, seen.last_flag);
        end
    endfunction

    // Compare every accepted line result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got.idx       = line_index;
            got.clip      = clip_x;
            got.height    = line_height;
            got.pivot     = pivot_y;
            got.pvalid    = pivot_valid;
            got.last_flag = last;
            n_checked++;
            if (line_q.size() == 0)
                log_error("unexpected line result", '0, got);
            else if (got.idx !== line_q[0].idx || got.clip !== line_q[0].clip
                     || got.height !== line_q[0].height || got.pivot !== line_q[0].pivot
                     || got.pvalid !== line_q[0].pvalid
                     || got.last_flag !== line_q[0].last_flag)
                log_error("line mismatch", line_q.pop_front(), got);
            else
                void'(line_q.pop_front());
        end
    end

    // Receiver: ready with random stall bursts while idling is on.
    initial
    begin
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Send one item, with an optional gap before it, and predict its lines.
    task automatic send_item(input logic op, input logic [SPEED_W-1:0] ns,
                             input logic [MS_W-1:0] ms, input logic [HEIGHT_W-1:0] th);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid         <= 1'b1;
        opcode           <= op;
        normalized_speed <= ns;
        frame_ms         <= ms;
        target_height    <= th;
        do
            @(posedge clk);
        while (!in_ready);
        predict_lines(op, ns, ms, th);
        if (op == OP_SCALE)
            n_scale++;
        else
            n_scroll++;
    endtask

    task automatic drain_lines();
        int waited;
        waited = 0;
        while (line_q.size() != 0 && waited < DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        model_write(idx, data);
    endtask

    // Write all registers once the block has gone idle.
    task automatic configure(input logic [CFG_DAT_W-1:0] lim,
                             input logic [CFG_DAT_W-1:0] lines,
                             input logic [CFG_DAT_W-1:0] speed, input bit touch_spare);
        @(negedge clk);
        in_valid <= 1'b0;
        drain_lines();
        repeat (4) @(posedge clk);
        cfg_put(CFG_LIMIT, lim);
        cfg_put(CFG_LINES, lines);
        cfg_put(CFG_SPEED, speed);
        if (touch_spare)
            cfg_put(CFG_SPARE, 16'hFFFF);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Register reset values: no scroll movement and the default line split.
    task automatic test_reset_values();
        send_item(OP_SCROLL, 16'sd16384, 8'd255, 10'd0);
        send_item(OP_SCALE, 16'sd0, 8'd0, 10'd100);
    endtask

    // Scroll steps at the extremes of speed, factor and frame time.
    task automatic test_scroll_steps();
        configure(16'd1023, 16'd8, 16'hFFFF, 1'b0);
        send_item(OP_SCROLL, 16'sd16384, 8'd12, 10'h3FF);
        send_item(OP_SCROLL, -16'sd16384, 8'd255, 10'd0);
        send_item(OP_SCROLL, 16'sd32767, 8'd255, 10'd0);
        send_item(OP_SCROLL, -16'sd32768, 8'd255, 10'd0);
        send_item(OP_SCROLL, 16'sd0, 8'd0, 10'd0);
        send_item(OP_SCROLL, 16'sd1, 8'd1, 10'd0);
    endtask

    // Limit lowered under the offset on both sides, and zero limit with zero lines.
    task automatic test_limit_edges();
        configure(16'd1023, 16'd4, 16'hFFFF, 1'b0);
        send_item(OP_SCROLL, 16'sd16384, 8'd12, 10'd0);
        configure(16'd100, 16'd4, 16'd0, 1'b0);
        send_item(OP_SCROLL, 16'sd0, 8'd0, 10'd0);
        configure(16'd1023, 16'd64, 16'hFFFF, 1'b0);
        send_item(OP_SCROLL, -16'sd16384, 8'd80, 10'd0);
        configure(16'd100, 16'd64, 16'd0, 1'b0);
        send_item(OP_SCROLL, 16'sd0, 8'd0, 10'd0);
        configure(16'd0, 16'd0, 16'hFFFF, 1'b0);
        send_item(OP_SCROLL, -16'sd16384, 8'd255, 10'd0);
    endtask

    // Height splits with zero heights, full height, clipped and single line counts.
    task automatic test_scale_split();
        configure(16'hFC40, 16'd7, 16'd0, 1'b1);
        send_item(OP_SCALE, 16'sd0, 8'd0, 10'd0);
        send_item(OP_SCALE, 16'sd0, 8'd0, 10'd1);
        send_item(OP_SCALE, 16'sd0, 8'd0, 10'd6);
        send_item(OP_SCALE, 16'sd0, 8'd0, 10'd1023);
        configure(16'd64, 16'd127, 16'd0, 1'b0);
        send_item(OP_SCALE, 16'sd0, 8'd0, 10'd1023);
        send_item(OP_SCALE, 16'sd0, 8'd0, 10'd37);
        configure(16'd64, 16'hFF81, 16'd0, 1'b0);
        send_item(OP_SCALE, 16'sd0, 8'd0, 10'd1023);
    endtask

    // Random register settings, each followed by a burst of random items.
    task automatic test_random_mix();
        logic [LIM_W-1:0]     lim;
        logic [N_W-1:0]       lines;
        logic [SPEED_W-1:0]   speed;
        logic [SPEED_W-1:0]   ns;
        logic [HEIGHT_W-1:0]  th;
        int                   top_lines;
        int                   count;

        for (int p = 0; p < 7; p++)
        begin
            top_lines = (p == 3) ? MAX_LINES : 12;
            count     = (p == 3) ? 4 : 16;
            idle_on   = (p < 6);

            case ($urandom_range(0, 7))
                0: lim = '0;
                1: lim = 10'd1;
                2: lim = 10'd1023;
                default: lim = LIM_W'($urandom_range(1, 1023));
            endcase
            if (p == 3)
                lines = N_W'(MAX_LINES);
            else if ($urandom_range(0, 9) == 0)
                lines = '0;
            else
                lines = N_W'($urandom_range(1, top_lines));
            case ($urandom_range(0, 3))
                0: speed = 16'hFFFF;
                1: speed = SPEED_W'($urandom_range(0, 500));
                default: speed = SPEED_W'($urandom_range(0, 65535));
            endcase
            configure({6'($urandom_range(0, 63)), lim}, {9'($urandom_range(0, 511)), lines},
                      speed, 1'b0);

            for (int k = 0; k < count; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                    ns = SPEED_W'($urandom_range(0, 65535));
                else
                    ns = SPEED_W'(int'($urandom_range(0, 32768)) - 16384);
                if ($urandom_range(0, 2) == 0)
                    th = HEIGHT_W'($urandom_range(0, 2 * top_lines));
                else
                    th = HEIGHT_W'($urandom_range(0, 1023));
                send_item(logic'($urandom_range(0, 1)), ns, MS_W'($urandom_range(0, 255)), th);
            end
        end
    endtask

    // Overall time limit, well above the slowest correct run.
    initial
    begin
        #25_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_valid         = 1'b0;
        opcode           = OP_SCROLL;
        normalized_speed = '0;
        frame_ms         = '0;
        target_height    = '0;
        err_count        = 0;
        n_scroll         = 0;
        n_scale          = 0;
        n_checked        = 0;
        idle_on          = 1'b1;
        model_limit      = LIMIT_RESET;
        model_lines      = LINES_RESET;
        model_speed      = SPEED_RESET;
        model_offset     = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_scroll_steps();
        test_limit_edges();
        test_scale_split();
        test_random_mix();

        // Let the last lines drain, then watch for stray results.
        @(negedge clk);
        in_valid <= 1'b0;
        drain_lines();
        repeat (100) @(posedge clk);
        if (line_q.size() != 0)
        begin
            $display("%0d line results never arrived", line_q.size());
            err_count += line_q.size();
        end

        $display("Covered %0d scroll and %0d scale items under extreme and random settings,",
                 n_scroll, n_scale);
        $display("%0d line results checked, %0d mismatches.", n_checked, err_count);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
